// ===== src/path_corner_advance_assert.svh =====
// Assertion macros shared by the path corner advance checker.
// Depends on nothing; taken in by `include.
`ifndef PATH_CORNER_ADVANCE_ASSERT_SVH
`define PATH_CORNER_ADVANCE_ASSERT_SVH

// Clocked assertion, switched off while the asynchronous reset is asserted.
`define PCA_ASSERT_RST(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define PCA_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/pca_pkg.sv =====
// Shared types and constants of the path corner advance block.
// Depends on nothing; used by every module of the block.
`default_nettype none

package pca_pkg;

	// Fixed-point format of coordinates
	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 31;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PROD_W    = 2 * DIFF_W;
	localparam int SQ_W      = 2 * COORD_W;
	localparam int SUM_W     = SQ_W + 1;

	// Configuration register map
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MODE     = 2'd1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic [SQ_W-1:0]           sq_t;
	typedef logic [SUM_W-1:0]          sum_t;

	// Segments with squared length below 1e-6 m^2 count as degenerate
	localparam sum_t DEGEN_LIMIT =
		sum_t'(((64'd1 << (2 * FRAC_BITS)) + 64'd999999) / 64'd1000000);

	typedef struct packed {
		logic [COORD_W-1:0] accept_radius;
		logic               hold_mode;
	} cfg_t;

	// Stage 1: differences against vehicle and previous point
	typedef struct packed {
		logic   first;
		logic   last;
		coord_t x;
		coord_t y;
		diff_t  dx;
		diff_t  dy;
		diff_t  sx;
		diff_t  sy;
		diff_t  px;
		diff_t  py;
	} s1_t;

	// Stage 2: products
	typedef struct packed {
		logic   first;
		logic   last;
		coord_t x;
		coord_t y;
		sq_t    dd_x;
		sq_t    dd_y;
		sq_t    ss_x;
		sq_t    ss_y;
		prod_t  dot_x;
		prod_t  dot_y;
		sq_t    rr;
	} s2_t;

	// Stage 3: sums of products
	typedef struct packed {
		logic   first;
		logic   last;
		coord_t x;
		coord_t y;
		sum_t   d2;
		sum_t   seg2;
		prod_t  dot;
		sq_t    rr;
	} s3_t;

endpackage

`default_nettype wire

// ===== src/path_corner_advance.sv =====
// Path corner advance: top level with configuration registers and stage chain.
// Depends on pca_pkg, pca_front, pca_mult, pca_sum and pca_decide.
//
// Usage:
//   Path points arrive on the input channel (in_valid/in_ready), one word per
//   point, first_point marking the start of a path; the vehicle position is
//   taken from the first point's word. The result channel (out_valid/out_ready)
//   carries one word per last point: the first corner that is not passed, or
//   the last point, with target_valid low for a path of a single point.
//   Configuration writes go through cfg_valid/cfg_ready with cfg_index and
//   cfg_data; index 0 is the acceptance radius, index 1 hold mode, other
//   indexes are ignored. Write only while no point is in flight.
//   A point loads stage 1 at the edge that takes it, then moves through stages
//   2 and 3 and into the result register. Throughput: one point per cycle while
//   no stalled result word backs up the stages; the multiply stage and the wide
//   compare each get a stage of their own.
//   In hold mode points are taken every cycle and dropped.
//   When the receiver stalls, the result register holds and the pipeline keeps
//   taking points until it is full; points that give no result pass through.
//   Reset clears the pipeline, the path state, the radius to 1.0 m and hold mode.
`default_nettype none

module path_corner_advance (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  pca_pkg::coord_t                    point_x,
	input  pca_pkg::coord_t                    point_y,
	input  logic                               first_point,
	input  logic                               last_point,
	input  pca_pkg::coord_t                    vehicle_x,
	input  pca_pkg::coord_t                    vehicle_y,
	output logic                               out_valid,
	input  logic                               out_ready,
	output pca_pkg::coord_t                    target_x,
	output pca_pkg::coord_t                    target_y,
	output logic                               target_valid,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pca_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pca_pkg::COORD_W-1:0]        cfg_data
);

	pca_pkg::cfg_t cfg_q;
	pca_pkg::s1_t  item_s1;
	pca_pkg::s2_t  item_s2;
	pca_pkg::s3_t  item_s3;
	logic          valid_s1, valid_s2, valid_s3;
	logic          ready_s2, ready_s3, ready_s4;

	// Configuration registers; writes always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accept_radius <= pca_pkg::COORD_W'(1 << pca_pkg::FRAC_BITS);
			cfg_q.hold_mode     <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == pca_pkg::CFG_ACCEPT_RADIUS) begin
				cfg_q.accept_radius <= cfg_data;
			end else if (cfg_index == pca_pkg::CFG_HOLD_MODE) begin
				cfg_q.hold_mode <= cfg_data[0];
			end
		end
	end

	pca_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.point_x     (point_x),
		.point_y     (point_y),
		.first_point (first_point),
		.last_point  (last_point),
		.vehicle_x   (vehicle_x),
		.vehicle_y   (vehicle_y),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1),
		.ready_s2    (ready_s2)
	);

	pca_mult u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.ready_s2 (ready_s2),
		.valid_s2 (valid_s2),
		.item_s2  (item_s2),
		.ready_s3 (ready_s3)
	);

	pca_sum u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.item_s2  (item_s2),
		.ready_s3 (ready_s3),
		.valid_s3 (valid_s3),
		.item_s3  (item_s3),
		.ready_s4 (ready_s4)
	);

	pca_decide u_decide (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s3     (valid_s3),
		.item_s3      (item_s3),
		.ready_s4     (ready_s4),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.target_x     (target_x),
		.target_y     (target_y),
		.target_valid (target_valid)
	);

endmodule

`default_nettype wire

// ===== src/pca_front.sv =====
// Input stage: path state tracking and coordinate differences.
// Depends on pca_pkg.
`default_nettype none

module pca_front (
	input  logic            clk,
	input  logic            arst_n,
	input  pca_pkg::cfg_t   cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  pca_pkg::coord_t point_x,
	input  pca_pkg::coord_t point_y,
	input  logic            first_point,
	input  logic            last_point,
	input  pca_pkg::coord_t vehicle_x,
	input  pca_pkg::coord_t vehicle_y,
	output logic            valid_s1,
	output pca_pkg::s1_t    item_s1,
	input  logic            ready_s2
);

	pca_pkg::coord_t prev_x_q, prev_y_q;
	pca_pkg::coord_t held_x_q, held_y_q;
	pca_pkg::s1_t    item_d;
	logic            take;

	// Drop words outright in hold mode
	assign in_ready = cfg.hold_mode | ~valid_s1 | ready_s2;
	assign take     = in_valid & in_ready & ~cfg.hold_mode;

	// Form the differences used by the distance and projection tests
	always_comb begin
		item_d.first = first_point;
		item_d.last  = last_point;
		item_d.x     = point_x;
		item_d.y     = point_y;
		item_d.dx    = pca_pkg::diff_t'(held_x_q) - pca_pkg::diff_t'(point_x);
		item_d.dy    = pca_pkg::diff_t'(held_y_q) - pca_pkg::diff_t'(point_y);
		item_d.sx    = pca_pkg::diff_t'(point_x) - pca_pkg::diff_t'(prev_x_q);
		item_d.sy    = pca_pkg::diff_t'(point_y) - pca_pkg::diff_t'(prev_y_q);
		item_d.px    = pca_pkg::diff_t'(held_x_q) - pca_pkg::diff_t'(prev_x_q);
		item_d.py    = pca_pkg::diff_t'(held_y_q) - pca_pkg::diff_t'(prev_y_q);
	end

	// Track previous point and latched vehicle position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
			held_x_q <= '0;
			held_y_q <= '0;
		end else if (take) begin
			prev_x_q <= point_x;
			prev_y_q <= point_y;
			if (first_point) begin
				held_x_q <= vehicle_x;
				held_y_q <= vehicle_y;
			end
		end
	end

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (ready_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/pca_mult.sv =====
// Multiply stage: squares, dot product terms and squared radius.
// Depends on pca_pkg.
`default_nettype none

module pca_mult (
	input  logic         clk,
	input  logic         arst_n,
	input  pca_pkg::cfg_t cfg,
	input  logic         valid_s1,
	input  pca_pkg::s1_t item_s1,
	output logic         ready_s2,
	output logic         valid_s2,
	output pca_pkg::s2_t item_s2,
	input  logic         ready_s3
);

	pca_pkg::prod_t p_dx, p_dy, p_sx, p_sy;
	pca_pkg::s2_t   item_d;
	logic           load;

	assign ready_s2 = ~valid_s2 | ready_s3;
	assign load     = valid_s1 & ready_s2;

	// One multiplier per product
	assign p_dx = item_s1.dx * item_s1.dx;
	assign p_dy = item_s1.dy * item_s1.dy;
	assign p_sx = item_s1.sx * item_s1.sx;
	assign p_sy = item_s1.sy * item_s1.sy;

	always_comb begin
		item_d.first = item_s1.first;
		item_d.last  = item_s1.last;
		item_d.x     = item_s1.x;
		item_d.y     = item_s1.y;
		item_d.dd_x  = p_dx[pca_pkg::SQ_W-1:0];
		item_d.dd_y  = p_dy[pca_pkg::SQ_W-1:0];
		item_d.ss_x  = p_sx[pca_pkg::SQ_W-1:0];
		item_d.ss_y  = p_sy[pca_pkg::SQ_W-1:0];
		item_d.dot_x = item_s1.px * item_s1.sx;
		item_d.dot_y = item_s1.py * item_s1.sy;
		item_d.rr    = cfg.accept_radius * cfg.accept_radius;
	end

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (ready_s3) begin
			valid_s2 <= 1'b0;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (load) begin
			item_s2 <= item_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/pca_sum.sv =====
// Sum stage: squared distance, squared segment length and dot product.
// Depends on pca_pkg.
`default_nettype none

module pca_sum (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         valid_s2,
	input  pca_pkg::s2_t item_s2,
	output logic         ready_s3,
	output logic         valid_s3,
	output pca_pkg::s3_t item_s3,
	input  logic         ready_s4
);

	pca_pkg::s3_t item_d;
	logic         load;

	assign ready_s3 = ~valid_s3 | ready_s4;
	assign load     = valid_s2 & ready_s3;

	// Add product pairs; squares are nonnegative, the dot product is signed
	always_comb begin
		item_d.first = item_s2.first;
		item_d.last  = item_s2.last;
		item_d.x     = item_s2.x;
		item_d.y     = item_s2.y;
		item_d.d2    = {1'b0, item_s2.dd_x} + {1'b0, item_s2.dd_y};
		item_d.seg2  = {1'b0, item_s2.ss_x} + {1'b0, item_s2.ss_y};
		item_d.dot   = item_s2.dot_x + item_s2.dot_y;
		item_d.rr    = item_s2.rr;
	end

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (load) begin
			valid_s3 <= 1'b1;
		end else if (ready_s4) begin
			valid_s3 <= 1'b0;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (load) begin
			item_s3 <= item_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/pca_decide.sv =====
// Decision stage: corner pass tests, target selection and result register.
// Depends on pca_pkg.
`default_nettype none

module pca_decide (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s3,
	input  pca_pkg::s3_t    item_s3,
	output logic            ready_s4,
	output logic            out_valid,
	input  logic            out_ready,
	output pca_pkg::coord_t target_x,
	output pca_pkg::coord_t target_y,
	output logic            target_valid
);

	pca_pkg::coord_t chosen_x_q, chosen_y_q;
	pca_pkg::coord_t target_x_q, target_y_q;
	logic            target_valid_q;
	logic            advancing_q;
	logic            out_valid_q;
	logic            consume;
	logic            emit;
	logic            in_radius;
	logic            seg_ok;
	logic            beyond;
	logic            done;

	// Only a word that emits has to wait for the result register
	assign ready_s4 = ~valid_s3 | ~item_s3.last | ~out_valid_q | out_ready;
	assign consume  = valid_s3 & ready_s4;
	assign emit     = consume & item_s3.last;

	// Corner pass tests: inside radius, or projected at or past the corner of a non-degenerate segment
	assign in_radius = item_s3.d2 < pca_pkg::sum_t'(item_s3.rr);
	assign seg_ok    = item_s3.seg2 >= pca_pkg::DEGEN_LIMIT;
	assign beyond    = ~item_s3.dot[pca_pkg::PROD_W-1] &
		(item_s3.dot[pca_pkg::SUM_W-1:0] >= item_s3.seg2);
	assign done      = in_radius | (seg_ok & beyond);

	// Advance through corners until one fails
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			advancing_q <= 1'b1;
			chosen_x_q  <= '0;
			chosen_y_q  <= '0;
		end else if (consume) begin
			if (item_s3.first) begin
				advancing_q <= 1'b1;
			end else if (advancing_q) begin
				chosen_x_q <= item_s3.x;
				chosen_y_q <= item_s3.y;
				if (!item_s3.last && !done) begin
					advancing_q <= 1'b0;
				end
			end
		end
	end

	// Result word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result word payload; a single-point path gives a zero target
	always_ff @(posedge clk) begin
		if (emit) begin
			if (item_s3.first) begin
				target_x_q     <= '0;
				target_y_q     <= '0;
				target_valid_q <= 1'b0;
			end else if (advancing_q) begin
				target_x_q     <= item_s3.x;
				target_y_q     <= item_s3.y;
				target_valid_q <= 1'b1;
			end else begin
				target_x_q     <= chosen_x_q;
				target_y_q     <= chosen_y_q;
				target_valid_q <= 1'b1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign target_x     = target_x_q;
	assign target_y     = target_y_q;
	assign target_valid = target_valid_q;

endmodule

`default_nettype wire

// ===== src/path_corner_advance_checker.sv =====
// Port-level checks of the path corner advance block, bound to the top level.
// Depends on pca_pkg and path_corner_advance_assert.svh.
`default_nettype none

`include "path_corner_advance_assert.svh"

module path_corner_advance_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  pca_pkg::coord_t               target_x,
	input  pca_pkg::coord_t               target_y,
	input  logic                          target_valid
);

	// Hold a stalled result word
	`PCA_ASSERT_RST(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "result word dropped while stalled")

	// Keep a stalled result word unchanged
	`PCA_ASSERT_RST(a_out_stable, clk, arst_n, out_valid && !out_ready |=> $stable(target_x) && $stable(target_y) && $stable(target_valid), "stalled result word changed")

	// A single-point path reports a zero target
	`PCA_ASSERT_RST(a_single_zero, clk, arst_n, out_valid && !target_valid |-> target_x == 0 && target_y == 0, "invalid target not zero")

	// No result word once reset has been seen at an edge
	`PCA_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> !out_valid, "result word shown during reset")

endmodule

bind path_corner_advance path_corner_advance_checker u_checker (.*);

`default_nettype wire

// ===== test/path_corner_advance_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for path_corner_advance: directed and random paths, idling.
// Depends on pca_pkg and the path_corner_advance RTL; checks results with a local predictor.

module path_corner_advance_tb;

	localparam longint COORD_MAX = 64'sd1073741823;
	localparam longint COORD_MIN = -64'sd1073741824;
	localparam longint unsigned SHORT_SEG =
		((64'd1 << (2 * pca_pkg::FRAC_BITS)) + 64'd999999) / 64'd1000000;
	localparam int SETTLE_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_POINTS = 140;

	typedef struct {
		pca_pkg::coord_t x;
		pca_pkg::coord_t y;
		logic            first;
		logic            last;
		pca_pkg::coord_t vx;
		pca_pkg::coord_t vy;
	} path_point_t;

	typedef struct {
		pca_pkg::coord_t x;
		pca_pkg::coord_t y;
		logic            valid;
	} target_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	pca_pkg::coord_t point_x = '0;
	pca_pkg::coord_t point_y = '0;
	logic first_point = 1'b0;
	logic last_point = 1'b0;
	pca_pkg::coord_t vehicle_x = '0;
	pca_pkg::coord_t vehicle_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	pca_pkg::coord_t target_x;
	pca_pkg::coord_t target_y;
	logic target_valid;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [pca_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pca_pkg::COORD_W-1:0] cfg_data = '0;

	// Stimulus and scoreboard
	path_point_t points_pending[$];
	target_t targets_due[$];
	int points_queued = 0;
	int points_taken = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	logic in_taken = 1'b0;
	logic out_taken = 1'b0;
	logic cfg_taken = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	bit sender_eager = 1'b0;
	bit receiver_eager = 1'b0;

	// Predictor state, mirrors the block's registers and path tracking
	logic [pca_pkg::COORD_W-1:0] radius_cfg = 31'd65536;
	bit hold_cfg = 1'b0;
	longint last_x = 0;
	longint last_y = 0;
	longint aim_x = 0;
	longint aim_y = 0;
	longint veh_x = 0;
	longint veh_y = 0;
	bit advancing = 1'b1;

	path_corner_advance uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.point_x      (point_x),
		.point_y      (point_y),
		.first_point  (first_point),
		.last_point   (last_point),
		.vehicle_x    (vehicle_x),
		.vehicle_y    (vehicle_y),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.target_x     (target_x),
		.target_y     (target_y),
		.target_valid (target_valid),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	// Pass test for a corner: inside the radius, or vehicle projected at or past it
	function automatic bit corner_cleared(longint cx, longint cy);
		longint dx, dy, sx, sy, px, py, dot;
		longint unsigned d2, seg2, rr;
		dx = veh_x - cx;
		dy = veh_y - cy;
		d2 = dx * dx + dy * dy;
		rr = longint'(radius_cfg) * longint'(radius_cfg);
		if (d2 < rr)
			return 1'b1;
		sx = cx - last_x;
		sy = cy - last_y;
		seg2 = sx * sx + sy * sy;
		// a near-zero segment never counts as overshot
		if (seg2 < SHORT_SEG)
			return 1'b0;
		px = veh_x - last_x;
		py = veh_y - last_y;
		dot = px * sx + py * sy;
		return dot >= 0 && dot >= longint'(seg2);
	endfunction

	// Advance the path tracker by one accepted word; return 1 when it yields a target
	function automatic bit follow_point(input path_point_t p, output target_t t);
		t.x = '0;
		t.y = '0;
		t.valid = 1'b0;
		if (hold_cfg)
			return 1'b0;
		if (p.first) begin
			veh_x = longint'(p.vx);
			veh_y = longint'(p.vy);
			last_x = longint'(p.x);
			last_y = longint'(p.y);
			advancing = 1'b1;
			return p.last;
		end
		if (advancing) begin
			aim_x = longint'(p.x);
			aim_y = longint'(p.y);
			if (!p.last && !corner_cleared(longint'(p.x), longint'(p.y)))
				advancing = 1'b0;
		end
		last_x = longint'(p.x);
		last_y = longint'(p.y);
		if (p.last) begin
			t.x = pca_pkg::coord_t'(aim_x);
			t.y = pca_pkg::coord_t'(aim_y);
			t.valid = 1'b1;
		end
		return p.last;
	endfunction

	function automatic longint fit_coord(longint v);
		if (v > COORD_MAX)
			return COORD_MAX;
		if (v < COORD_MIN)
			return COORD_MIN;
		return v;
	endfunction

	// Signed coordinate spread over roughly +/- 2^span
	function automatic longint pick_coord(int span);
		logic signed [31:0] raw;
		raw = $urandom;
		return longint'(raw) >>> (31 - span);
	endfunction

	task automatic queue_point(longint x, longint y, bit first, bit last, longint vx, longint vy);
		path_point_t p;
		p.x = pca_pkg::coord_t'(fit_coord(x));
		p.y = pca_pkg::coord_t'(fit_coord(y));
		p.first = first;
		p.last = last;
		p.vx = pca_pkg::coord_t'(fit_coord(vx));
		p.vy = pca_pkg::coord_t'(fit_coord(vy));
		points_pending.push_back(p);
		points_queued++;
	endtask

	// Well-formed path: first word with vehicle, corners shaped to hit each pass rule, last word
	task automatic queue_path();
		int span, corners, mode, k;
		longint vx, vy, ax, ay, cx, cy, reach;
		span = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(8, 29);
		vx = pick_coord(span);
		vy = pick_coord(span);
		ax = pick_coord(span);
		ay = pick_coord(span);
		if ($urandom_range(0, 9) == 0) begin
			queue_point(ax, ay, 1'b1, 1'b1, vx, vy);
			return;
		end
		queue_point(ax, ay, 1'b1, 1'b0, vx, vy);
		corners = $urandom_range(0, 6);
		reach = longint'(radius_cfg);
		for (int n = 0; n <= corners; n++) begin
			mode = $urandom_range(0, 3);
			case (mode)
				0: begin
					// near the vehicle, inside or just outside the radius
					cx = vx + longint'($urandom_range(0, 32'(2 * reach))) - reach;
					cy = vy + longint'($urandom_range(0, 32'(2 * reach))) - reach;
				end
				1: begin
					// along the line toward the vehicle, short of it or past it
					k = $urandom_range(0, 10);
					cx = ax + (vx - ax) * k / 8 + longint'($urandom_range(0, 512)) - 256;
					cy = ay + (vy - ay) * k / 8 + longint'($urandom_range(0, 512)) - 256;
				end
				2: begin
					cx = pick_coord(span);
					cy = pick_coord(span);
				end
				default: begin
					// tiny step off the previous corner, around the degenerate limit
					cx = ax + longint'($urandom_range(0, 160)) - 80;
					cy = ay + longint'($urandom_range(0, 160)) - 80;
				end
			endcase
			cx = fit_coord(cx);
			cy = fit_coord(cy);
			queue_point(cx, cy, 1'b0, n == corners, pick_coord(30), pick_coord(30));
			ax = cx;
			ay = cy;
		end
	endtask

	// Stray word with random markers: breaks paths apart or continues a closed one
	task automatic queue_noise();
		queue_point(pick_coord(30), pick_coord(30), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), pick_coord(30), pick_coord(30));
	endtask

	// Hold off until every word is in and every target is out, then let the pipe drain
	task automatic settle();
		while (points_taken != points_queued || targets_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [pca_pkg::CFG_IDX_W-1:0] idx,
		logic [pca_pkg::COORD_W-1:0] value);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do
			@(negedge clk);
		while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	// Drive point words from the pending queue with a random gap before each
	always @(negedge clk) begin : point_driver
		path_point_t nxt;
		if (arst_n && (!in_valid || in_taken)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (points_pending.size() > 0) begin
				nxt = points_pending.pop_front();
				point_x <= nxt.x;
				point_y <= nxt.y;
				first_point <= nxt.first;
				last_point <= nxt.last;
				vehicle_x <= nxt.vx;
				vehicle_y <= nxt.vy;
				in_valid <= 1'b1;
				send_gap <= sender_eager ? 0 : $urandom_range(0, 13);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the result side for a random count after each word taken
	always @(negedge clk) begin : target_sink
		int stall_now;
		if (arst_n) begin
			if (out_taken)
				stall_now = receiver_eager ? 0 : $urandom_range(0, 13);
			else
				stall_now = stall_left;
			if (stall_now > 0) begin
				out_ready <= 1'b0;
				stall_left <= stall_now - 1;
			end else begin
				out_ready <= 1'b1;
				stall_left <= 0;
			end
		end
	end

	// Sample handshakes, predict, compare, and watch for a stuck pipeline
	always @(posedge clk) begin : monitor
		path_point_t seen;
		target_t want;
		target_t fresh;
		if (!arst_n) begin
			in_taken <= 1'b0;
			out_taken <= 1'b0;
			cfg_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && in_ready;
			out_taken <= out_valid && out_ready;
			cfg_taken <= cfg_valid && cfg_ready;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pca_pkg::CFG_ACCEPT_RADIUS: radius_cfg = cfg_data;
					pca_pkg::CFG_HOLD_MODE:     hold_cfg = cfg_data[0];
					default: ;
				endcase
			end

			if (out_valid && out_ready) begin
				if (targets_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected target word: x=%0d y=%0d valid=%0b",
							target_x, target_y, target_valid);
				end else begin
					want = targets_due.pop_front();
					if (target_x !== want.x || target_y !== want.y ||
						target_valid !== want.valid) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp %0d %0d %0b, got %0d %0d %0b",
								want.x, want.y, want.valid,
								target_x, target_y, target_valid);
					end
				end
			end

			if (in_valid && in_ready) begin
				seen.x = point_x;
				seen.y = point_y;
				seen.first = first_point;
				seen.last = last_point;
				seen.vx = vehicle_x;
				seen.vy = vehicle_y;
				points_taken++;
				if (follow_point(seen, fresh))
					targets_due.push_back(fresh);
			end

			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("path_corner_advance verification failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int goal;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: first words after reset with no first point seen
		queue_point(100000, 0, 1'b0, 1'b0, COORD_MAX, COORD_MIN);
		queue_point(COORD_MIN, COORD_MAX, 1'b0, 1'b1, COORD_MIN, COORD_MAX);
		// single-point path at the extremes
		queue_point(COORD_MAX, COORD_MIN, 1'b1, 1'b1, COORD_MIN, COORD_MAX);
		// words after a last point, no new first
		queue_point(-5, 7, 1'b0, 1'b0, 0, 0);
		queue_point(COORD_MAX, COORD_MAX, 1'b0, 1'b1, COORD_MAX, COORD_MAX);
		// segment just below the degenerate limit, vehicle far ahead
		queue_point(0, 0, 1'b1, 1'b0, 260000, 32000);
		queue_point(65, 8, 1'b0, 1'b0, 0, 0);
		queue_point(COORD_MAX, 0, 1'b0, 1'b1, 0, 0);
		// segment just above the limit
		queue_point(0, 0, 1'b1, 1'b0, 260000, 32000);
		queue_point(65, 10, 1'b0, 1'b0, 0, 0);
		queue_point(-1, -1, 1'b0, 1'b1, 0, 0);
		// projection exactly at the corner, then a corner left behind
		queue_point(0, 0, 1'b1, 1'b0, 1000000, 500000);
		queue_point(1000000, 0, 1'b0, 1'b0, 0, 0);
		queue_point(2000000, 0, 1'b0, 1'b0, 0, 0);
		queue_point(3, 3, 1'b0, 1'b1, 0, 0);
		// projection one unit short
		queue_point(0, 0, 1'b1, 1'b0, 999999, 500000);
		queue_point(1000000, 0, 1'b0, 1'b0, 0, 0);
		queue_point(7, 7, 1'b0, 1'b1, 0, 0);
		// distance exactly the radius, then one unit inside
		queue_point(0, 0, 1'b1, 1'b0, 0, 0);
		queue_point(65536, 0, 1'b0, 1'b0, 0, 0);
		queue_point(5, 5, 1'b0, 1'b1, 0, 0);
		queue_point(0, 0, 1'b1, 1'b0, 0, 0);
		queue_point(65535, 0, 1'b0, 1'b0, 0, 0);
		queue_point(COORD_MIN, COORD_MIN, 1'b0, 1'b0, COORD_MIN, COORD_MIN);
		queue_point(COORD_MAX, COORD_MAX, 1'b0, 1'b1, COORD_MAX, COORD_MAX);

		// Random phases under a range of radii and idling mixes
		for (int ph = 0; ph < 8; ph++) begin
			settle();
			if (ph == 4) begin
				// hold mode: every word dropped, tracker state kept
				write_reg(pca_pkg::CFG_HOLD_MODE, 31'd1);
				for (int n = 0; n < 40; n++) begin
					if ($urandom_range(0, 1))
						queue_noise();
					else
						queue_path();
				end
				settle();
				write_reg(pca_pkg::CFG_HOLD_MODE, 31'd0);
			end
			case (ph)
				1: write_reg(pca_pkg::CFG_ACCEPT_RADIUS, 31'd0);
				2: write_reg(pca_pkg::CFG_ACCEPT_RADIUS, 31'd1);
				3: write_reg(pca_pkg::CFG_ACCEPT_RADIUS, 31'd1073741824);
				4: write_reg(pca_pkg::CFG_ACCEPT_RADIUS, 31'($urandom_range(0, 1073741824)));
				5: write_reg(pca_pkg::CFG_ACCEPT_RADIUS, 31'd1048576);
				6: write_reg(pca_pkg::CFG_ACCEPT_RADIUS, 31'($urandom_range(0, 262144)));
				7: write_reg(pca_pkg::CFG_ACCEPT_RADIUS, 31'd65536);
				default: ;
			endcase
			sender_eager = (ph % 3 == 2);
			receiver_eager = (ph % 4 == 1);
			goal = points_queued + PHASE_POINTS;
			while (points_queued < goal) begin
				if ($urandom_range(0, 99) < 12)
					queue_noise();
				else
					queue_path();
			end
		end

		settle();
		if (mismatches == 0)
			$display("path_corner_advance verification clean");
		else
			$display("path_corner_advance verification failed");
		$finish;
	end

endmodule
